### rtl/depth_pitch_heading_pd_autopilot_top_assert.svh
// Assertion macros for the depth/pitch/heading PD autopilot.
// Included inside module bodies that have clk_i and rst_ni in scope.
`ifndef DEPTH_PITCH_HEADING_PD_AUTOPILOT_TOP_ASSERT_SVH
`define DEPTH_PITCH_HEADING_PD_AUTOPILOT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DPHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DPHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpha_pkg.sv
// Package for the depth/pitch/heading PD autopilot: register indices,
// reset values, fixed gains and the saturating loop-term arithmetic.
// No dependencies.
`default_nettype none

package dpha_pkg;

  // Configuration register indices
  localparam logic [2:0] RegDepthSp   = 3'd0;
  localparam logic [2:0] RegHeadingSp = 3'd1;
  localparam logic [2:0] RegPropSpeed = 3'd2;
  localparam logic [2:0] RegDepthKp   = 3'd3;
  localparam logic [2:0] RegDepthKd   = 3'd4;
  localparam logic [2:0] RegHeadingKp = 3'd5;
  localparam logic [2:0] RegHeadingKd = 3'd6;
  localparam logic [2:0] RegSurfLimit = 3'd7;

  // Reset values (gains Q8.8, limit Q16.16)
  localparam logic [15:0] DepthKpRst   = 16'd768;   // 3.0
  localparam logic [15:0] DepthKdRst   = 16'd768;   // 3.0
  localparam logic [15:0] HeadingKpRst = 16'd768;   // 3.0
  localparam logic [15:0] HeadingKdRst = 16'd3123;  // ~12.199
  localparam logic [30:0] SurfLimitRst = 31'd1310720; // 20.0

  // Pitch loop has fixed kp = kd = 3.0
  localparam logic [15:0] PitchGain = 16'd768;

  // Widest intermediate: 16x32 products summed, plus rounding headroom
  localparam int unsigned AccW = 49;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } clamp_t;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32'sh7fff_ffff);
    lo = AccW'(32'sh8000_0000);  // signed literal, sign-extends to -2^31
    if (x > hi) begin
      return 32'sh7fff_ffff;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // kp*err + kd*rate (Q24.24), round half up to Q16.16, saturate
  function automatic logic signed [31:0] loop_term(input logic signed [31:0] err,
                                                    input logic signed [31:0] rate,
                                                    input logic [15:0] kp,
                                                    input logic [15:0] kd);
    logic signed [47:0]     p_term;
    logic signed [47:0]     d_term;
    logic signed [AccW-1:0] acc;
    p_term = $signed({1'b0, kp}) * err;
    d_term = $signed({1'b0, kd}) * rate;
    acc    = AccW'(p_term) + AccW'(d_term) + AccW'(48'sd128);
    return sat32(acc >>> 8);
  endfunction

endpackage

`default_nettype wire

### rtl/depth_pitch_heading_pd_autopilot_top.sv
// Depth, pitch and heading PD autopilot, top level.
// Depends on dpha_pkg and depth_pitch_heading_pd_autopilot_top_assert.svh.
//
// Usage:
//  - Slave stream carries one vehicle state sample per word: depth, pitch
//    and yaw, each signed Q16.16. Master stream returns one command word
//    per sample: elevator, rudder and propeller speed in tdata, clip flags
//    in tuser.
//  - Registers (setpoints, gains, surface limit, propeller speed) are
//    written via the cfg port, one per cycle, effective at the next edge.
//    Write only while the block is empty; the block does not enforce it.
//  - Two register stages: stage A takes the errors and error rates (and
//    updates the stored previous errors at acceptance), stage B holds the
//    finished command, which it offers on the master side until taken.
//  - Throughput is one word per clock while the receiver keeps up; the
//    two 16x32 multiplies per loop and the round/saturate/clamp chain
//    sit between stage A and stage B.
//  - If the receiver stalls, stage B holds its word and stage A can still
//    take one more sample; tready then drops until the receiver takes
//    the held word. Nothing is dropped or duplicated.
//  - Reset (asynchronous, active low) empties both stages, clears the
//    stored previous errors and loads the register reset values
//    (gains 3.0/3.0/3.0/12.2, limit 20.0, setpoints and speed zero).
`default_nettype none

module depth_pitch_heading_pd_autopilot_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // sample stream in
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,  // depth_measured, pitch_measured, yaw_measured
  // command stream out
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [95:0] m_axis_tdata_o,  // elevator_cmd, rudder_cmd, speed_cmd
  output      logic [1:0]  m_axis_tuser_o   // elevator_clipped, rudder_clipped
);

  import dpha_pkg::*;

  // ---------------- configuration registers ----------------
  logic        [30:0] depth_sp_q;
  logic signed [31:0] heading_sp_q;
  logic        [31:0] prop_speed_q;
  logic        [15:0] depth_kp_q;
  logic        [15:0] depth_kd_q;
  logic        [15:0] heading_kp_q;
  logic        [15:0] heading_kd_q;
  logic        [30:0] surf_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_sp_q   <= '0;
      heading_sp_q <= '0;
      prop_speed_q <= '0;
      depth_kp_q   <= DepthKpRst;
      depth_kd_q   <= DepthKdRst;
      heading_kp_q <= HeadingKpRst;
      heading_kd_q <= HeadingKdRst;
      surf_limit_q <= SurfLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegDepthSp:   depth_sp_q   <= cfg_wdata_i[30:0];
        RegHeadingSp: heading_sp_q <= $signed(cfg_wdata_i);
        RegPropSpeed: prop_speed_q <= cfg_wdata_i;
        RegDepthKp:   depth_kp_q   <= cfg_wdata_i[15:0];
        RegDepthKd:   depth_kd_q   <= cfg_wdata_i[15:0];
        RegHeadingKp: heading_kp_q <= cfg_wdata_i[15:0];
        RegHeadingKd: heading_kd_q <= cfg_wdata_i[15:0];
        RegSurfLimit: surf_limit_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic a_valid_q;
  logic o_valid_q;
  logic out_adv;   // stage B can take a word this cycle
  logic s_accept;
  logic a_adv;

  assign out_adv         = !o_valid_q || m_axis_tready_i;
  assign a_adv           = a_valid_q && out_adv;
  assign s_axis_tready_o = !a_valid_q || out_adv;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- stage A: errors and rates ----------------
  logic signed [31:0] depth_in;
  logic signed [31:0] pitch_in;
  logic signed [31:0] yaw_in;

  assign depth_in = $signed(s_axis_tdata_i[31:0]);
  assign pitch_in = $signed(s_axis_tdata_i[63:32]);
  assign yaw_in   = $signed(s_axis_tdata_i[95:64]);

  logic signed [31:0] last_zerr_q, last_perr_q, last_herr_q;

  logic signed [33:0] zerr_full;
  logic signed [32:0] perr_full;
  logic signed [32:0] herr_full;
  logic signed [31:0] zerr_d, perr_d, herr_d;
  logic signed [31:0] zrate_d, prate_d, hrate_d;

  // (err - prev) * 20, saturated
  function automatic logic signed [31:0] err_rate(input logic signed [31:0] err,
                                                  input logic signed [31:0] prev);
    logic signed [32:0] diff;
    logic signed [37:0] scaled;
    diff   = 33'(err) - 33'(prev);
    scaled = (38'(diff) <<< 4) + (38'(diff) <<< 2);
    return sat32(AccW'(scaled));
  endfunction

  always_comb begin
    zerr_full = $signed({3'b000, depth_sp_q}) - 34'(depth_in);
    perr_full = 33'sd0 - 33'(pitch_in);
    herr_full = 33'(heading_sp_q) - 33'(yaw_in);
    zerr_d    = sat32(AccW'(zerr_full));
    perr_d    = sat32(AccW'(perr_full));
    herr_d    = sat32(AccW'(herr_full));
    zrate_d   = err_rate(zerr_d, last_zerr_q);
    prate_d   = err_rate(perr_d, last_perr_q);
    hrate_d   = err_rate(herr_d, last_herr_q);
  end

  logic signed [31:0] a_zerr_q, a_perr_q, a_herr_q;
  logic signed [31:0] a_zrate_q, a_prate_q, a_hrate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      last_zerr_q <= '0;
      last_perr_q <= '0;
      last_herr_q <= '0;
    end else begin
      if (s_accept) begin
        a_valid_q   <= 1'b1;
        last_zerr_q <= zerr_d;
        last_perr_q <= perr_d;
        last_herr_q <= herr_d;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      a_zerr_q  <= zerr_d;
      a_perr_q  <= perr_d;
      a_herr_q  <= herr_d;
      a_zrate_q <= zrate_d;
      a_prate_q <= prate_d;
      a_hrate_q <= hrate_d;
    end
  end

  // ---------------- stage B: PD terms, sum, clamp ----------------
  logic signed [31:0] depth_term, pitch_term, rudder_raw;
  logic signed [31:0] elev_raw;
  logic signed [31:0] lim_pos, lim_neg;
  clamp_t             elev_d, rud_d;

  function automatic clamp_t clamp_cmd(input logic signed [31:0] v,
                                       input logic signed [31:0] hi,
                                       input logic signed [31:0] lo);
    clamp_t r;
    if (v >= hi) begin
      r.value = hi;
      r.clip  = 1'b1;
    end else if (v <= lo) begin
      r.value = lo;
      r.clip  = 1'b1;
    end else begin
      r.value = v;
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  assign lim_pos = $signed({1'b0, surf_limit_q});
  assign lim_neg = -lim_pos;  // fits: limit is at most 2^31-1

  always_comb begin
    depth_term = loop_term(a_zerr_q, a_zrate_q, depth_kp_q, depth_kd_q);
    pitch_term = loop_term(a_perr_q, a_prate_q, PitchGain, PitchGain);
    rudder_raw = loop_term(a_herr_q, a_hrate_q, heading_kp_q, heading_kd_q);
    elev_raw   = sat32(AccW'(depth_term) + AccW'(pitch_term));
    elev_d     = clamp_cmd(elev_raw, lim_pos, lim_neg);
    rud_d      = clamp_cmd(rudder_raw, lim_pos, lim_neg);
  end

  clamp_t      elev_q, rud_q;
  logic [31:0] speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_adv) begin
      o_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      elev_q  <= elev_d;
      rud_q   <= rud_d;
      speed_q <= prop_speed_q;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {speed_q, rud_q.value, elev_q.value};
  assign m_axis_tuser_o  = {rud_q.clip, elev_q.clip};

  // ---------------- assertions ----------------
  `include "depth_pitch_heading_pd_autopilot_top_assert.svh"

  `DPHA_ASSERT_NXT(a_state_tracks_accept, s_accept, last_zerr_q == a_zerr_q && last_herr_q == a_herr_q, "stored error differs from accepted word")
  `DPHA_ASSERT_NXT(a_stage_holds, a_valid_q && !out_adv && !s_accept, a_valid_q && $stable(a_zerr_q), "stage A lost a stalled word")
  `DPHA_ASSERT_IMP(a_elev_clip_at_limit, o_valid_q && elev_q.clip, elev_q.value == lim_pos || elev_q.value == lim_neg, "elevator clip without limit value")
  `DPHA_ASSERT_IMP(a_rud_inside, o_valid_q && !rud_q.clip, rud_q.value < lim_pos && rud_q.value > lim_neg, "rudder outside limit but not clipped")

endmodule

`default_nettype wire
